>>> src/mtwp_pkg.sv
`default_nettype none
package mtwp_pkg;

  // table geometry
  localparam int MAX_POPS     = 16;
  localparam int IDX_BITS     = $clog2(MAX_POPS);
  localparam int CELL_BITS    = 2 * IDX_BITS;
  localparam int ADDR_BITS    = CELL_BITS + 1;
  localparam int SIZE_BITS    = $clog2(MAX_POPS + 1);

  // word fields
  localparam int WEIGHT_BITS  = 24;
  localparam int TOTAL_BITS   = 32;
  localparam int RAND_BITS    = 32;
  localparam int PROD_BITS    = RAND_BITS + TOTAL_BITS;
  localparam int KIND_BITS    = 2;
  localparam int STATUS_BITS  = 2;

  // configuration registers
  localparam int POP_BITS      = 5;
  localparam int MODEL_BITS    = 3;
  localparam int RATE_BITS     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int GRID_BITS     = 2 * POP_BITS + 1;

  localparam logic [POP_BITS-1:0]   POP_RESET = POP_BITS'(4);

  localparam logic [CFG_IDX_BITS-1:0] CFG_POP_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATE      = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_DRAW  = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NONE  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

  localparam logic [MODEL_BITS-1:0] MODEL_ISLAND = 3'd0;
  localparam logic [MODEL_BITS-1:0] MODEL_RING   = 3'd1;
  localparam logic [MODEL_BITS-1:0] MODEL_CHAIN  = 3'd2;
  localparam logic [MODEL_BITS-1:0] MODEL_TORUS  = 3'd3;
  localparam logic [MODEL_BITS-1:0] MODEL_ALL    = 3'd4;
  localparam logic [MODEL_BITS-1:0] MODEL_EMPTY  = 3'd5;

  typedef struct packed {
    logic                   cap;
    logic                   clr_step;
    logic                   wr_go;
    logic                   bld_go;
    logic                   bld_step;
    logic                   drw_go;
    logic                   sum_scan;
    logic                   drw_scan;
    logic                   set_res;
    logic [STATUS_BITS-1:0] res_status;
    logic                   load_out;
  } mtwp_cmd_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 wr_ok;
    logic                 total_zero;
    logic                 sweep_last;
    logic                 data_last;
    logic                 hit;
  } mtwp_sts_t;

endpackage
`default_nettype wire

>>> src/mtwp_if.sv
`default_nettype none
interface mtwp_in_if;
  logic                             valid;
  logic                             ready;
  logic [mtwp_pkg::KIND_BITS-1:0]   kind;
  logic [mtwp_pkg::IDX_BITS-1:0]    source_index;
  logic [mtwp_pkg::IDX_BITS-1:0]    sink_index;
  logic [mtwp_pkg::WEIGHT_BITS-1:0] weight;
  logic [mtwp_pkg::RAND_BITS-1:0]   random_fraction;

  modport source (output valid, kind, source_index, sink_index, weight, random_fraction,
                  input ready);
  modport sink   (input valid, kind, source_index, sink_index, weight, random_fraction,
                  output ready);
endinterface

interface mtwp_out_if;
  logic                             valid;
  logic                             ready;
  logic [mtwp_pkg::IDX_BITS-1:0]    picked_source;
  logic [mtwp_pkg::IDX_BITS-1:0]    picked_sink;
  logic [mtwp_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, picked_source, picked_sink, status, input ready);
  modport sink   (input valid, picked_source, picked_sink, status, output ready);
endinterface
`default_nettype wire

>>> src/mtwp_ctrl.sv
`default_nettype none
module mtwp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mtwp_pkg::mtwp_sts_t sts,
  output mtwp_pkg::mtwp_cmd_t      cmd
);
  import mtwp_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DISP = 3'd2;
  localparam logic [2:0] ST_BLD  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DRAW = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = STATUS_OK;
        case (sts.kind)
          KIND_WRITE: begin
            if (sts.wr_ok) begin
              cmd.wr_go = 1'b1;
              state_nxt = ST_SUM;
            end else begin
              cmd.res_status = STATUS_RANGE;
              state_nxt      = ST_RESP;
            end
          end
          KIND_BUILD: begin
            cmd.bld_go = 1'b1;
            state_nxt  = ST_BLD;
          end
          KIND_DRAW: begin
            if (sts.total_zero) begin
              cmd.res_status = STATUS_NONE;
              state_nxt      = ST_RESP;
            end else begin
              cmd.drw_go = 1'b1;
              state_nxt  = ST_DRAW;
            end
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_BLD: begin
        cmd.bld_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_RESP;
      end
      ST_SUM: begin
        cmd.sum_scan = 1'b1;
        if (sts.data_last) state_nxt = ST_RESP;
      end
      ST_DRAW: begin
        cmd.drw_scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_RESP;
        end else if (sts.data_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STATUS_NONE;
          state_nxt      = ST_RESP;
        end
      end
      ST_RESP: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> src/mtwp_dp.sv
`default_nettype none
module mtwp_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mtwp_pkg::mtwp_cmd_t                 cmd,
  output mtwp_pkg::mtwp_sts_t                      sts,
  input  wire logic [mtwp_pkg::KIND_BITS-1:0]      in_kind,
  input  wire logic [mtwp_pkg::IDX_BITS-1:0]       in_source_index,
  input  wire logic [mtwp_pkg::IDX_BITS-1:0]       in_sink_index,
  input  wire logic [mtwp_pkg::WEIGHT_BITS-1:0]    in_weight,
  input  wire logic [mtwp_pkg::RAND_BITS-1:0]      in_random_fraction,
  input  wire logic                                cfg_we,
  input  wire logic [mtwp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mtwp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output logic [mtwp_pkg::IDX_BITS-1:0]            out_picked_source,
  output logic [mtwp_pkg::IDX_BITS-1:0]            out_picked_sink,
  output logic [mtwp_pkg::STATUS_BITS-1:0]         out_status
);
  import mtwp_pkg::*;

  localparam int CELLS_T = MAX_POPS * MAX_POPS;

  // configuration
  logic [POP_BITS-1:0]    pop_r;
  logic [MODEL_BITS-1:0]  model_r;
  logic [RATE_BITS-1:0]   rate_r;

  // captured word
  logic [KIND_BITS-1:0]   kind_r;
  logic [IDX_BITS-1:0]    src_r, snk_r;
  logic [WEIGHT_BITS-1:0] wgt_r;
  logic [RAND_BITS-1:0]   rnd_r;

  // table and sweep
  logic [WEIGHT_BITS-1:0] mem [CELLS_T];
  logic [ADDR_BITS-1:0]   addr_r;
  logic                   rd_vld_r;
  logic [CELL_BITS-1:0]   rd_addr_r;
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   rd_en, mem_we;
  logic [CELL_BITS-1:0]   waddr;
  logic [WEIGHT_BITS-1:0] wdata;

  // totals
  logic [TOTAL_BITS-1:0]  acc_r, total_r;
  logic [SIZE_BITS-1:0]   active_r;
  logic [PROD_BITS-1:0]   target_r;
  logic [WEIGHT_BITS-1:0] add_in;
  logic [TOTAL_BITS:0]    acc_sum;
  logic [TOTAL_BITS-1:0]  acc_sat, cum;
  logic                   hit;

  // build
  logic [MODEL_BITS-1:0]  bld_model_r;
  logic [WEIGHT_BITS-1:0] bld_w_r;
  logic [POP_BITS-1:0]    side_r, ti_r, tj_r;
  logic [GRID_BITS-1:0]   slast_r;
  logic [2*POP_BITS-1:0]  sq, slast_prod;
  logic [POP_BITS-1:0]    pm1;
  logic [SIZE_BITS-1:0]   tsize, nclamp;
  logic [IDX_BITS-1:0]    row, col;
  logic [SIZE_BITS-1:0]   rowx, colx;
  logic                   in_act, sel, tor_hit, ti_last, tj_last, row_end;
  logic [GRID_BITS-1:0]   rg, cg, sg, jg, t_left, t_right, t_up, t_down;
  logic [WEIGHT_BITS-1:0] cell_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r   <= POP_RESET;
      model_r <= MODEL_ISLAND;
      rate_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POP_COUNT: pop_r   <= cfg_wdata[POP_BITS-1:0];
        CFG_MODEL:     model_r <= cfg_wdata[MODEL_BITS-1:0];
        CFG_RATE:      rate_r  <= cfg_wdata[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= in_kind;
      src_r  <= in_source_index;
      snk_r  <= in_sink_index;
      wgt_r  <= in_weight;
      rnd_r  <= in_random_fraction;
    end
  end

  // build parameters
  assign sq         = (2*POP_BITS)'(pop_r) * (2*POP_BITS)'(pop_r);
  assign pm1        = pop_r - POP_BITS'(1);
  assign slast_prod = (2*POP_BITS)'(pm1) * (2*POP_BITS)'(pop_r);
  assign tsize      = (sq > (2*POP_BITS)'(MAX_POPS)) ? SIZE_BITS'(MAX_POPS)
                                                      : sq[SIZE_BITS-1:0];
  assign nclamp     = (POP_BITS'(pop_r) > POP_BITS'(MAX_POPS)) ? SIZE_BITS'(MAX_POPS)
                                                                : SIZE_BITS'(pop_r);

  // cell under the sweep
  assign row  = addr_r[CELL_BITS-1:IDX_BITS];
  assign col  = addr_r[IDX_BITS-1:0];
  assign rowx = SIZE_BITS'(row);
  assign colx = SIZE_BITS'(col);
  assign in_act  = (rowx < active_r) && (colx < active_r);
  assign row_end = (col == {IDX_BITS{1'b1}});

  // torus neighbors of the current grid node (ti_r, tj_r)
  assign rg      = GRID_BITS'(row);
  assign cg      = GRID_BITS'(col);
  assign sg      = GRID_BITS'(side_r);
  assign jg      = GRID_BITS'(tj_r);
  assign tj_last = (tj_r == side_r - POP_BITS'(1));
  assign ti_last = (ti_r == side_r - POP_BITS'(1));
  assign t_left  = (tj_r == '0) ? rg + sg - GRID_BITS'(1) : rg - GRID_BITS'(1);
  assign t_right = tj_last ? rg - sg + GRID_BITS'(1) : rg + GRID_BITS'(1);
  assign t_up    = (ti_r == '0) ? slast_r + jg : rg - sg;
  assign t_down  = ti_last ? jg : rg + sg;
  assign tor_hit = (cg == t_left) || (cg == t_right) || (cg == t_up) || (cg == t_down);

  always_comb begin
    case (bld_model_r)
      MODEL_RING:  sel = (rowx == colx + SIZE_BITS'(1)) || (colx == rowx + SIZE_BITS'(1)) ||
                         ((active_r >= SIZE_BITS'(2)) &&
                          (((rowx == active_r - SIZE_BITS'(1)) && (colx == '0)) ||
                           ((rowx == '0) && (colx == active_r - SIZE_BITS'(1)))));
      MODEL_CHAIN: sel = (rowx == colx + SIZE_BITS'(1)) || (colx == rowx + SIZE_BITS'(1));
      MODEL_TORUS: sel = tor_hit;
      MODEL_ALL:   sel = 1'b1;
      MODEL_EMPTY: sel = 1'b0;
      default:     sel = (rowx != colx);
    endcase
  end

  assign cell_w = (in_act && sel) ? bld_w_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.bld_go) begin
      bld_model_r <= model_r;
      bld_w_r     <= rate_r[WEIGHT_BITS-1:0];
      side_r      <= pop_r;
      slast_r     <= GRID_BITS'(slast_prod);
      ti_r        <= '0;
      tj_r        <= '0;
    end else if (cmd.bld_step && row_end) begin
      // step the grid coordinates to the next row
      if (tj_r + POP_BITS'(1) == side_r) begin
        tj_r <= '0;
        ti_r <= ti_r + POP_BITS'(1);
      end else begin
        tj_r <= tj_r + POP_BITS'(1);
      end
    end
  end

  // table memory
  assign rd_en  = (cmd.sum_scan || cmd.drw_scan) && !addr_r[ADDR_BITS-1];
  assign mem_we = cmd.clr_step || cmd.bld_step || cmd.wr_go;
  assign waddr  = cmd.wr_go ? {src_r, snk_r} : addr_r[CELL_BITS-1:0];
  assign wdata  = cmd.wr_go ? wgt_r : (cmd.bld_step ? cell_w : '0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (rd_en) rd_data_r <= mem[addr_r[CELL_BITS-1:0]];
    rd_addr_r <= addr_r[CELL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.wr_go || cmd.bld_go || cmd.drw_go) begin
        addr_r <= '0;
      end else if (cmd.clr_step || cmd.bld_step || rd_en) begin
        addr_r <= addr_r + ADDR_BITS'(1);
      end
    end
  end

  // running sum, saturating; during a draw clamp to the total
  assign add_in  = cmd.bld_step ? cell_w : rd_data_r;
  assign acc_sum = (TOTAL_BITS+1)'(acc_r) + (TOTAL_BITS+1)'(add_in);
  assign acc_sat = acc_sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : acc_sum[TOTAL_BITS-1:0];
  assign cum     = (acc_sat > total_r) ? total_r : acc_sat;
  assign hit     = rd_vld_r && (rd_data_r != '0) &&
                   ((cum > target_r[PROD_BITS-1:RAND_BITS]) ||
                    ((cum == target_r[PROD_BITS-1:RAND_BITS]) &&
                     (target_r[RAND_BITS-1:0] == '0)));

  always_ff @(posedge clk) begin
    if (cmd.drw_go) target_r <= PROD_BITS'(rnd_r) * PROD_BITS'(total_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      total_r  <= '0;
      active_r <= '0;
    end else begin
      if (cmd.wr_go || cmd.bld_go || cmd.drw_go) acc_r <= '0;
      if (cmd.bld_go) active_r <= (model_r == MODEL_TORUS) ? tsize : nclamp;
      if (cmd.bld_step) begin
        acc_r <= acc_sat;
        if (addr_r[CELL_BITS-1:0] == {CELL_BITS{1'b1}}) total_r <= acc_sat;
      end
      if (cmd.sum_scan && rd_vld_r) begin
        acc_r <= acc_sat;
        if (rd_addr_r == {CELL_BITS{1'b1}}) total_r <= acc_sat;
      end
      if (cmd.drw_scan && rd_vld_r && (rd_data_r != '0)) acc_r <= cum;
    end
  end

  // result registers
  logic [IDX_BITS-1:0]    res_src_r, res_snk_r;
  logic [STATUS_BITS-1:0] res_sts_r;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_src_r <= '0;
      res_snk_r <= '0;
      res_sts_r <= cmd.res_status;
    end else if (cmd.drw_scan && hit) begin
      res_src_r <= rd_addr_r[CELL_BITS-1:IDX_BITS];
      res_snk_r <= rd_addr_r[IDX_BITS-1:0];
    end
    if (cmd.load_out) begin
      out_picked_source <= res_src_r;
      out_picked_sink   <= res_snk_r;
      out_status        <= res_sts_r;
    end
  end

  assign sts.kind       = kind_r;
  assign sts.wr_ok      = (SIZE_BITS'(src_r) < active_r) && (SIZE_BITS'(snk_r) < active_r);
  assign sts.total_zero = (total_r == '0);
  assign sts.sweep_last = (addr_r[CELL_BITS-1:0] == {CELL_BITS{1'b1}});
  assign sts.data_last  = rd_vld_r && (rd_addr_r == {CELL_BITS{1'b1}});
  assign sts.hit        = hit;

endmodule
`default_nettype wire

>>> src/migration_table_weighted_pair_picker.sv
`default_nettype none
// Channel   Dir  Handshake             Word
// in_ch     in   valid/ready           kind, source_index, sink_index, weight,
//                                      random_fraction
// out_ch    out  valid/ready           picked_source, picked_sink, status
// cfg_*     in   cfg_we (no back-off)  cfg_index 0 pop_count, 1 model, 2 rate
//
// One word at a time. Build: one table cell written per cycle.
// Write: the table is read back to refresh the total. Draw: the table is walked
// one cell per cycle until the pick; a draw with a zero total, a write out of
// range and an unused kind skip the sweep and go straight to the response.
// Reset runs a clearing pass over the table; in_ch.ready stays low.
// A finished result waits in the output register; a new word is taken meanwhile.
module migration_table_weighted_pair_picker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  mtwp_in_if.sink                                  in_ch,
  mtwp_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [mtwp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mtwp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import mtwp_pkg::*;

  mtwp_cmd_t cmd;
  mtwp_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  // sequence: clear, capture, dispatch, sweep, respond
  mtwp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, running total, cell generator, draw compare
  mtwp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_ch.kind),
    .in_source_index    (in_ch.source_index),
    .in_sink_index      (in_ch.sink_index),
    .in_weight          (in_ch.weight),
    .in_random_fraction (in_ch.random_fraction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_picked_source  (out_ch.picked_source),
    .out_picked_sink    (out_ch.picked_sink),
    .out_status         (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire
